>>> rtl/step_dir_pulse_generator_core_assert.svh
// Assertion macros for the step/direction pulse generator RTL.
`ifndef STEP_DIR_PULSE_GENERATOR_CORE_ASSERT_SVH
`define STEP_DIR_PULSE_GENERATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define SDPG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define SDPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SDPG_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define SDPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

>>> rtl/sdpg_pkg.sv
package sdpg_pkg;

   localparam int POS_W  = 32;
   localparam int PER_W  = 31;
   localparam int PW_W   = 10;
   localparam int MP_W   = 20;
   localparam int OPER_W = 31;
   localparam int WIDE_W = (OPER_W > MP_W) ? OPER_W : MP_W;
   localparam int PROD_W = 2 * PER_W;
   localparam int ADD_W  = PER_W + 2;
   localparam int CNT_W  = $clog2(PROD_W + 1);
   localparam int POS_EXT_W = (POS_W > 32) ? POS_W : 32;

   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 3;
   localparam int RSP_FIELD_W = 37;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = MP_W;

   localparam logic [PER_W-1:0] PER_MAX = '1;
   localparam logic [PW_W-1:0] PW_RESET = PW_W'(10);
   localparam logic [MP_W-1:0] MP_RESET = MP_W'(12);
   localparam logic [PER_W-1:0] TTE_FLOOR = PER_W'(2);

   localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(PER_W);
   localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(PROD_W);

   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_WIDTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PERIOD  = 1'b1;

   typedef enum logic [2:0] {
      FN_TICK       = 3'd0,
      FN_SET_PERIOD = 3'd1,
      FN_SET_DIR    = 3'd2,
      FN_ENABLE     = 3'd3,
      FN_ESTOP      = 3'd4,
      FN_CLR_ESTOP  = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WAIT
   } ctl_state_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV
   } md_state_type;

   typedef struct packed {
      logic             start;
      logic [PER_W-1:0] mcand;
      logic [PER_W-1:0] mplier;
      logic [PER_W-1:0] divisor;
   } md_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] quot;
   } md_rsp_type;

endpackage

>>> rtl/sdpg_muldiv.sv
// Serial multiply-then-divide: quot = mcand * mplier / divisor.
// One shared adder does a shift-add multiply step or a restoring divide step
// each cycle. The divisor must be nonzero.
module sdpg_muldiv
   import sdpg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  md_req_type md_req,
   output md_rsp_type md_rsp
);

   md_state_type      state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [PER_W-1:0]  rem_ff, rem_in;
   logic [PER_W-1:0]  mcand_ff, mcand_in;
   logic [PER_W-1:0]  div_ff, div_in;
   logic              done_ff, done_in;

   logic [PER_W:0]    shifted;
   logic [ADD_W-1:0]  add_a, add_b, add_sum;
   logic              add_sub;
   logic              ge;

   assign shifted = {rem_ff, prod_ff[PROD_W-1]};
   assign add_sum = add_a + (add_sub ? ~add_b : add_b) + ADD_W'(add_sub);
   assign ge      = ~add_sum[ADD_W-1];

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      mcand_in = mcand_ff;
      div_in   = div_ff;
      done_in  = 1'b0;
      add_a    = ADD_W'(prod_ff[PROD_W-1:PER_W]);
      add_b    = ADD_W'(mcand_ff);
      add_sub  = 1'b0;
      case (state_ff)
         MD_IDLE: begin
            if (md_req.start) begin
               prod_in  = {PER_W'(0), md_req.mplier};
               mcand_in = md_req.mcand;
               div_in   = md_req.divisor;
               cnt_in   = MUL_STEPS;
               state_in = MD_MUL;
            end
         end
         MD_MUL: begin
            if (prod_ff[0]) begin
               prod_in = {add_sum[PER_W:0], prod_ff[PER_W-1:1]};
            end else begin
               prod_in = {1'b0, prod_ff[PROD_W-1:1]};
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               cnt_in   = DIV_STEPS;
               rem_in   = '0;
               state_in = MD_DIV;
            end
         end
         MD_DIV: begin
            add_a   = ADD_W'(shifted);
            add_b   = ADD_W'(div_ff);
            add_sub = 1'b1;
            rem_in  = ge ? add_sum[PER_W-1:0] : shifted[PER_W-1:0];
            prod_in = {prod_ff[PROD_W-2:0], ge};
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               done_in  = 1'b1;
               state_in = MD_IDLE;
            end
         end
         default: begin
            state_in = MD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      mcand_ff <= mcand_in;
      div_ff   <= div_in;
   end

   assign md_rsp.done = done_ff;
   assign md_rsp.quot = prod_ff;

endmodule

>>> rtl/step_dir_pulse_generator_core.sv
// Channel   Direction  Fields
// req_      in         tuser: func; tdata: operand_value
// rsp_      out        tdata: step_out, dir_out, enable_out, position_count,
//                      is_running, status
// csr_      in         write only: pulse_width (0), min_period (1)
//
// Most transactions go through ST_EXEC, which loads the registered result and raises
// rsp_tvalid; the next can be accepted once the core is back in ST_IDLE.
// A retune of a running train with the output low runs the serial multiply/divide
// unit (PER_W + 2*PER_W steps) in ST_WAIT before rsp_tvalid rises.
// Reset is synchronous and restores the register defaults and the stopped state.
// A stalled rsp_ holds its result and blocks req_ until it is taken.
`include "step_dir_pulse_generator_core_assert.svh"

module step_dir_pulse_generator_core
   import sdpg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [30:0] operand_value
   input  logic [REQ_USER_W-1:0] req_tuser,  // [2:0] func
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] step_out, [1] dir_out, [2] enable_out, [34:3] position_count,
   // [35] is_running, [36] status
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   ctl_state_type         state_ff, state_in;
   func_type              func_ff;
   logic [OPER_W-1:0]     oper_ff;
   logic [PW_W-1:0]       pw_ff;
   logic [MP_W-1:0]       minp_ff;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [PER_W-1:0]      per_ff, per_in;
   logic [PER_W-1:0]      tte_ff, tte_in;
   logic [PER_W-1:0]      np_ff, np_in;
   logic                  lvl_ff, lvl_in;
   logic                  run_ff, run_in;
   logic                  estop_ff, estop_in;
   logic                  dir_ff, dir_in;
   logic                  en_ff, en_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  req_accept;
   logic                  load;
   logic                  refused;
   logic [WIDE_W-1:0]     v_wide, mp_wide, lo_wide;
   logic [PER_W-1:0]      eff_w, low_time, q_clamped;
   logic signed [POS_EXT_W-1:0] pos_ext;
   md_req_type            md_req;
   md_rsp_type            md_rsp;

   sdpg_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Requested period raised to the minimum, then saturated at the period width.
   assign v_wide  = WIDE_W'(oper_ff);
   assign mp_wide = WIDE_W'(minp_ff);
   assign lo_wide = (v_wide < mp_wide) ? mp_wide : v_wide;
   assign np_in   = (lo_wide > WIDE_W'(PER_MAX)) ? PER_MAX : lo_wide[PER_W-1:0];

   assign eff_w    = (pw_ff == '0) ? PER_W'(1) : PER_W'(pw_ff);
   assign low_time = (per_ff > eff_w) ? (per_ff - eff_w) : PER_W'(1);

   always_comb begin
      if (md_rsp.quot[PROD_W-1:PER_W] != '0) begin
         q_clamped = PER_MAX;
      end else if (md_rsp.quot[PER_W-1:0] < TTE_FLOOR) begin
         q_clamped = TTE_FLOOR;
      end else begin
         q_clamped = md_rsp.quot[PER_W-1:0];
      end
   end

   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      per_in         = per_ff;
      tte_in         = tte_ff;
      lvl_in         = lvl_ff;
      run_in         = run_ff;
      estop_in       = estop_ff;
      dir_in         = dir_ff;
      en_in          = en_ff;
      load           = 1'b0;
      refused        = 1'b0;
      md_req.start   = 1'b0;
      md_req.mcand   = tte_ff;
      md_req.mplier  = np_in;
      md_req.divisor = per_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            load     = 1'b1;
            case (func_ff)
               FN_TICK: begin
                  if (!run_ff || estop_ff) begin
                     run_in = 1'b0;
                     lvl_in = 1'b0;
                  end else if (tte_ff > PER_W'(1)) begin
                     tte_in = tte_ff - PER_W'(1);
                  end else if (!lvl_ff) begin
                     lvl_in = 1'b1;
                     pos_in = dir_ff ? (pos_ff + POS_W'(1)) : (pos_ff - POS_W'(1));
                     tte_in = eff_w;
                  end else begin
                     lvl_in = 1'b0;
                     tte_in = low_time;
                  end
               end
               FN_SET_PERIOD: begin
                  if (estop_ff) begin
                     refused = 1'b1;
                  end else if (oper_ff == '0) begin
                     run_in = 1'b0;
                     lvl_in = 1'b0;
                  end else if (!run_ff) begin
                     per_in = np_in;
                     tte_in = np_in;
                     lvl_in = 1'b0;
                     run_in = 1'b1;
                  end else if (!lvl_ff && (per_ff != np_in)) begin
                     if (per_ff == '0) begin
                        tte_in = (np_in < TTE_FLOOR) ? TTE_FLOOR : np_in;
                        per_in = np_in;
                     end else begin
                        // Remaining low time is rescaled by new/old period.
                        md_req.start = 1'b1;
                        load         = 1'b0;
                        state_in     = ST_WAIT;
                     end
                  end else begin
                     per_in = np_in;
                  end
               end
               FN_SET_DIR: begin
                  if (run_ff) begin
                     refused = 1'b1;
                  end else begin
                     dir_in = oper_ff[0];
                  end
               end
               FN_ENABLE: begin
                  if (!oper_ff[0]) begin
                     run_in = 1'b0;
                     lvl_in = 1'b0;
                  end
                  en_in = oper_ff[0] && !estop_ff;
               end
               FN_ESTOP: begin
                  estop_in = 1'b1;
                  run_in   = 1'b0;
                  lvl_in   = 1'b0;
                  en_in    = 1'b0;
               end
               FN_CLR_ESTOP: begin
                  estop_in = 1'b0;
               end
               default: begin
               end
            endcase
         end
         ST_WAIT: begin
            if (md_rsp.done) begin
               tte_in   = q_clamped;
               per_in   = np_ff;
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign pos_ext = POS_EXT_W'($signed(pos_in));

   assign rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign rsp_data_in  = load ?
      {(RSP_DATA_W - RSP_FIELD_W)'(0), refused, run_in, pos_ext[31:0], en_in, dir_in, lvl_in}
      : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pw_ff        <= PW_RESET;
         minp_ff      <= MP_RESET;
         pos_ff       <= '0;
         per_ff       <= '0;
         tte_ff       <= '0;
         lvl_ff       <= 1'b0;
         run_ff       <= 1'b0;
         estop_ff     <= 1'b0;
         dir_ff       <= 1'b1;
         en_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         per_ff       <= per_in;
         tte_ff       <= tte_in;
         lvl_ff       <= lvl_in;
         run_ff       <= run_in;
         estop_ff     <= estop_in;
         dir_ff       <= dir_in;
         en_ff        <= en_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && (csr_index == CSR_PULSE_WIDTH)) begin
            pw_ff <= csr_wdata[PW_W-1:0];
         end
         if (csr_we && (csr_index == CSR_MIN_PERIOD)) begin
            minp_ff <= csr_wdata[MP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (req_accept) begin
         func_ff <= func_type'(req_tuser);
         oper_ff <= req_tdata[OPER_W-1:0];
      end
      if (md_req.start) begin
         np_ff <= np_in;
      end
   end

   `SDPG_ASSERT_IMP(a_estop_stopped, clock, reset, estop_ff, !run_ff && !lvl_ff && !en_ff, "emergency stop with train or enable active")
   `SDPG_ASSERT_IMP(a_level_needs_run, clock, reset, lvl_ff, run_ff, "step output high while stopped")
   `SDPG_ASSERT_IMP(a_pos_unit_step, clock, reset, !$past(reset), (pos_ff == $past(pos_ff)) || (pos_ff == $past(pos_ff) + POS_W'(1)) || (pos_ff == $past(pos_ff) - POS_W'(1)), "position moved by more than one step")
   `SDPG_ASSERT_NEXT(a_rescale_result, clock, reset, (state_ff == ST_WAIT) && md_rsp.done, rsp_tvalid && (state_ff == ST_IDLE), "rescale finished without a result")

endmodule

>>> tb/sv/tb_step_dir_pulse_generator_core.sv
module tb_step_dir_pulse_generator_core;
   import sdpg_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned IDLE_PCT = 26;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned TAIL_CYCLES = 200;
   localparam logic [2:0] FN_UNUSED6 = 3'd6;
   localparam logic [2:0] FN_UNUSED7 = 3'd7;

   // Packed so that it lines up with rsp_tdata[36:0].
   typedef struct packed {
      logic        status;
      logic        running;
      logic [31:0] position;
      logic        enable;
      logic        dir;
      logic        step;
   } motion_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Predicted state of the pulse generator.
   logic [31:0]      pos_q;
   logic [PER_W-1:0] period_q;
   logic [PER_W-1:0] tte_q;
   logic             level_q;
   logic             running_q;
   logic             estop_q;
   logic             dir_q;
   logic             enable_q;
   logic [PW_W-1:0]  width_cfg;
   logic [MP_W-1:0]  minper_cfg;

   motion_result_type pending_outputs[$];

   int unsigned cycle_count;
   int unsigned error_count;
   int unsigned items_sent;
   int unsigned results_checked;
   int unsigned steps_predicted;
   int unsigned settings_used;
   int unsigned hold_count;
   bit          steady_mode;

   step_dir_pulse_generator_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [PER_W-1:0] high_ticks();
      return (width_cfg == '0) ? PER_W'(1) : PER_W'(width_cfg);
   endfunction

   function automatic void stop_train();
      running_q = 1'b0;
      level_q = 1'b0;
   endfunction

   function automatic void advance_tick();
      logic [PER_W-1:0] w;
      w = high_ticks();
      if (!running_q || estop_q) begin
         stop_train();
      end else if (tte_q > PER_W'(1)) begin
         tte_q = tte_q - PER_W'(1);
      end else if (!level_q) begin
         level_q = 1'b1;
         pos_q = dir_q ? pos_q + 32'd1 : pos_q - 32'd1;
         tte_q = w;
         steps_predicted++;
      end else begin
         level_q = 1'b0;
         tte_q = (period_q > w) ? period_q - w : PER_W'(1);
      end
   endfunction

   // Returns 1 when the new period is accepted.
   function automatic logic apply_period(logic [PER_W-1:0] val);
      longint unsigned new_per;
      longint unsigned scaled;
      if (estop_q) return 1'b0;
      if (val == '0) begin
         stop_train();
         return 1'b1;
      end
      new_per = (longint'(val) < longint'(minper_cfg)) ? longint'(minper_cfg) : longint'(val);
      if (new_per > longint'(PER_MAX)) new_per = longint'(PER_MAX);
      if (!running_q) begin
         period_q = PER_W'(new_per);
         level_q = 1'b0;
         tte_q = PER_W'(new_per);
         running_q = 1'b1;
      end else if (!level_q && longint'(period_q) != new_per) begin
         // Rescale the low time that is left to the new period.
         if (period_q != '0)
            scaled = (longint'(tte_q) * new_per) / longint'(period_q);
         else
            scaled = new_per;
         if (scaled < 2) scaled = 2;
         if (scaled > longint'(PER_MAX)) scaled = longint'(PER_MAX);
         tte_q = PER_W'(scaled);
         period_q = PER_W'(new_per);
      end else begin
         period_q = PER_W'(new_per);
      end
      return 1'b1;
   endfunction

   function automatic motion_result_type predict_outputs(logic [2:0] fn, logic [PER_W-1:0] val);
      motion_result_type r;
      logic refused;
      refused = 1'b0;
      case (fn)
         FN_TICK: advance_tick();
         FN_SET_PERIOD: refused = !apply_period(val);
         FN_SET_DIR: begin
            if (running_q) refused = 1'b1;
            else dir_q = val[0];
         end
         FN_ENABLE: begin
            if (!val[0]) stop_train();
            enable_q = val[0] && !estop_q;
         end
         FN_ESTOP: begin
            estop_q = 1'b1;
            stop_train();
            enable_q = 1'b0;
         end
         FN_CLR_ESTOP: estop_q = 1'b0;
         default: ;
      endcase
      r.status = refused;
      r.running = running_q;
      r.position = pos_q;
      r.enable = enable_q;
      r.dir = dir_q;
      r.step = level_q;
      return r;
   endfunction

   function automatic void reset_prediction();
      pos_q = '0;
      period_q = '0;
      tte_q = '0;
      level_q = 1'b0;
      running_q = 1'b0;
      estop_q = 1'b0;
      dir_q = 1'b1;
      enable_q = 1'b0;
      width_cfg = PW_RESET;
      minper_cfg = MP_RESET;
   endfunction

   // The stimulus tasks below start and end just after a falling edge.
   task automatic send_cmd(input logic [2:0] fn, input logic [PER_W-1:0] val);
      motion_result_type r;
      while (!steady_mode && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = fn;
      req_tdata = {1'b0, val};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = predict_outputs(fn, val);
      pending_outputs.push_back(r);
      items_sent++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_outputs.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_PULSE_WIDTH) width_cfg = val[PW_W-1:0];
      else minper_cfg = val[MP_W-1:0];
   endtask

   task automatic load_settings(input logic [PW_W-1:0] pw, input logic [MP_W-1:0] mp);
      wait_idle();
      write_reg(CSR_PULSE_WIDTH, CSR_DATA_W'(pw));
      write_reg(CSR_MIN_PERIOD, mp);
      settings_used++;
   endtask

   task automatic pick_item(output logic [2:0] fn, output logic [PER_W-1:0] val);
      int unsigned roll;
      int unsigned sel;
      logic [PER_W-1:0] noise;
      noise = PER_W'($urandom);
      roll = $urandom_range(99);
      val = noise;
      if (roll < 64) begin
         fn = FN_TICK;
      end else if (roll < 78) begin
         fn = FN_SET_PERIOD;
         sel = $urandom_range(99);
         if (sel < 8) val = '0;
         else if (sel < 60) val = PER_W'($urandom_range(1, 48));
         else if (sel < 75) val = PER_W'(minper_cfg) + PER_W'($urandom_range(0, 31));
         else if (sel < 92) val = noise;
         else val = PER_MAX;
      end else if (roll < 83) begin
         fn = FN_SET_DIR;
      end else if (roll < 89) begin
         fn = FN_ENABLE;
         val[0] = ($urandom_range(9) != 0);
      end else if (roll < 92) begin
         fn = FN_ESTOP;
      end else if (roll < 97) begin
         fn = FN_CLR_ESTOP;
      end else begin
         fn = $urandom_range(1) ? FN_UNUSED6 : FN_UNUSED7;
      end
   endtask

   task automatic test_random_traffic(input int unsigned count);
      logic [2:0] fn;
      logic [PER_W-1:0] val;
      repeat (count) begin
         pick_item(fn, val);
         send_cmd(fn, val);
      end
   endtask

   task automatic test_directed_cases();
      load_settings(PW_W'(1), MP_W'(2));
      send_cmd(FN_ENABLE, 31'h0000_0001);
      send_cmd(FN_SET_DIR, 31'h7FFF_FFFE);
      send_cmd(FN_UNUSED6, PER_MAX);
      send_cmd(FN_UNUSED7, 31'h0);
      send_cmd(FN_SET_PERIOD, 31'h1);           // raised to the minimum
      send_cmd(FN_TICK, 31'h0);
      send_cmd(FN_TICK, PER_MAX);               // rising edge, step down
      send_cmd(FN_SET_DIR, 31'h1);              // refused while running
      send_cmd(FN_TICK, 31'h0);                 // falling edge
      send_cmd(FN_SET_PERIOD, PER_MAX);         // retune low time upward
      send_cmd(FN_SET_PERIOD, 31'h5);           // retune back down, floor of two
      send_cmd(FN_TICK, 31'h0);
      send_cmd(FN_TICK, 31'h0);
      send_cmd(FN_SET_PERIOD, 31'h3);           // output high: period only
      send_cmd(FN_TICK, 31'h0);
      send_cmd(FN_ESTOP, PER_MAX);
      send_cmd(FN_SET_PERIOD, 31'h4);           // refused during emergency stop
      send_cmd(FN_TICK, 31'h0);
      send_cmd(FN_ENABLE, 31'h1);               // enable stays low while stopped
      send_cmd(FN_CLR_ESTOP, 31'h0);
      send_cmd(FN_ENABLE, PER_MAX);
      send_cmd(FN_SET_PERIOD, 31'h0);           // zero period stops the train
      send_cmd(FN_SET_DIR, PER_MAX);
      send_cmd(FN_ENABLE, 31'h7FFF_FFFE);       // bit 0 clear disables
   endtask

   task automatic test_config_sweep();
      load_settings(PW_RESET, MP_RESET);
      test_random_traffic(200);
      load_settings(PW_W'(1), MP_W'(2));
      test_random_traffic(200);
      load_settings(PW_W'(1023), MP_W'(1048575));
      test_random_traffic(60);
      // A zero width register is treated as one tick high.
      load_settings(PW_W'(0), MP_W'(5));
      test_random_traffic(150);
      // Minimum period below the pulse width: periods at or below the width leave a one tick low time.
      load_settings(PW_W'(20), MP_W'(8));
      test_random_traffic(150);
      load_settings(PW_W'($urandom_range(1, 15)), MP_W'($urandom_range(2, 40)));
      test_random_traffic(120);
   endtask

   task automatic test_input_stall();
      load_settings(PW_W'(3), MP_W'(7));
      steady_mode = 1'b1;
      test_random_traffic(40);
      // The receiver holds off while the sender keeps offering transactions.
      hold_count = 400;
      test_random_traffic(12);
      wait_idle();
      test_random_traffic(40);
      steady_mode = 1'b0;
      // Sender pauses until every outstanding result has been taken.
      wait_idle();
      test_random_traffic(60);
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_count > 0) begin
            hold_count--;
            rsp_tready = 1'b0;
         end else if (steady_mode) begin
            rsp_tready = 1'b1;
         end else begin
            rsp_tready = ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] got_v);
      if (exp_v !== got_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : check_results
      motion_result_type exp_r;
      motion_result_type got_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_r = rsp_tdata[RSP_FIELD_W-1:0];
         if (pending_outputs.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0h", $time, got_r);
            error_count++;
         end else begin
            exp_r = pending_outputs.pop_front();
            results_checked++;
            check_field("step_out", 32'(exp_r.step), 32'(got_r.step));
            check_field("dir_out", 32'(exp_r.dir), 32'(got_r.dir));
            check_field("enable_out", 32'(exp_r.enable), 32'(got_r.enable));
            check_field("position_count", exp_r.position, got_r.position);
            check_field("is_running", 32'(exp_r.running), 32'(got_r.running));
            check_field("status", 32'(exp_r.status), 32'(got_r.status));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, pending_outputs.size());
         $display("step_dir_pulse_generator_core verification failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cycle_count = 0;
      error_count = 0;
      items_sent = 0;
      results_checked = 0;
      steps_predicted = 0;
      settings_used = 0;
      hold_count = 0;
      steady_mode = 1'b0;
      reset_prediction();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_config_sweep();
      test_input_stall();

      while (pending_outputs.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Sent %0d transactions across %0d register settings, %0d step edges predicted.",
               items_sent, settings_used, steps_predicted);
      $display("Checked %0d results, %0d mismatches.", results_checked, error_count);
      if (error_count == 0) begin
         $display("step_dir_pulse_generator_core verification clean");
      end else begin
         $display("step_dir_pulse_generator_core verification failed");
      end
      $finish;
   end

endmodule
